// File: hw/rtl/sparse_transpose_scatter_index_assert.svh
// Assertion macros for the sparse transpose scatter-index block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SPARSE_TRANSPOSE_SCATTER_INDEX_ASSERT_SVH
`define SPARSE_TRANSPOSE_SCATTER_INDEX_ASSERT_SVH

// check a property on every clock edge outside reset
`define STSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define STSI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/stsi_pkg.sv
// Types, codes and sizes for the sparse transpose scatter-index block.
// No dependencies.
package stsi_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_NONZEROS = 65536;
  localparam int ROW_W        = $clog2(MAX_ROWS);
  localparam int CNT_W        = ROW_W + 1;
  localparam int POS_W        = 17;
  localparam int SUM_W        = POS_W + 1;
  localparam int COL_W        = 16;
  localparam int COEF_W       = 64;
  localparam int OP_W         = 2;
  localparam int ST_W         = 3;

  localparam logic [CNT_W-1:0] ROWS_LIMIT = CNT_W'(MAX_ROWS);
  localparam logic [SUM_W-1:0] NZ_LIMIT   = SUM_W'(MAX_NONZEROS);

  localparam logic [OP_W-1:0] OP_DECLARE = 2'd0;
  localparam logic [OP_W-1:0] OP_ENTRY   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK            = 3'd0;
  localparam logic [ST_W-1:0] ST_ROW_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_LOADED    = 3'd2;
  localparam logic [ST_W-1:0] ST_TOO_MANY_ROWS = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW      = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  row_size;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  col_index;
    logic [COEF_W-1:0] coef_bits;
  } in_beat_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [COL_W-1:0]  out_col;
    logic [COEF_W-1:0] out_coef_bits;
    logic [ST_W-1:0]   status;
  } out_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] fill_ptr;
    logic [POS_W-1:0] end_slot;
  } row_word_t;

  localparam int WORD_W = $bits(row_word_t);

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
    row_word_t        data;
  } row_wr_t;

endpackage

// File: hw/rtl/sparse_transpose_scatter_index.sv
// Top level of the sparse transpose scatter-index block: row table RAM,
// update stage with write forwarding, output register.
// Depends on stsi_pkg, stsi_ram, stsi_update, the assertion header.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | in_data  (stsi_pkg::in_beat_t)
//   out_    | out | out_valid/out_stall| out_data (stsi_pkg::out_beat_t)
//
// One beat per cycle sustained while the output is not stalled. Each beat's
// row word is read from the RAM and the beat captured at the accepting edge;
// its update goes into the output register when the update stage commits.
// The fill pointer read-modify-write sets the rate; a write to the row read
// by the next beat is forwarded.
// Synchronous active-low reset clears prefix sum, row count and valids.
// A stalled output holds the update stage, which stalls the input.
`include "sparse_transpose_scatter_index_assert.svh"

module sparse_transpose_scatter_index (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stsi_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stsi_pkg::out_beat_t out_data
);
  import stsi_pkg::*;

  logic             s1_v_r, s1_v_nxt;
  in_beat_t         s1_beat_r;
  logic             fwd_hit_r;
  row_word_t        fwd_word_r;
  logic             out_v_r, out_v_nxt;
  out_beat_t        out_beat_r;
  logic [CNT_W-1:0] rows_loaded_r, rows_loaded_nxt;
  logic [POS_W-1:0] running_total_r, running_total_nxt;

  logic             in_acc;
  logic             s1_go;
  logic             commit;
  logic [WORD_W-1:0] ram_rd;
  row_word_t        row_word;
  out_beat_t        result;
  row_wr_t          row_wr;
  row_wr_t          row_wr_g;

  assign s1_go    = !out_v_r || !out_stall;
  assign commit   = s1_v_r && s1_go;
  assign in_stall = s1_v_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    row_wr_g    = row_wr;
    row_wr_g.en = row_wr.en && commit;
  end

  stsi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_wr_g.en),
    .wr_addr (row_wr_g.addr),
    .wr_data (row_wr_g.data),
    .rd_en   (in_acc),
    .rd_addr (in_data.row_index),
    .rd_data (ram_rd)
  );

  assign row_word = fwd_hit_r ? fwd_word_r : row_word_t'(ram_rd);

  stsi_update u_update (
    .beat              (s1_beat_r),
    .row_word          (row_word),
    .rows_loaded       (rows_loaded_r),
    .running_total     (running_total_r),
    .result            (result),
    .row_wr            (row_wr),
    .rows_loaded_nxt   (rows_loaded_nxt),
    .running_total_nxt (running_total_nxt)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (commit) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (commit) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r          <= 1'b0;
      out_v_r         <= 1'b0;
      rows_loaded_r   <= '0;
      running_total_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (commit) begin
        rows_loaded_r   <= rows_loaded_nxt;
        running_total_r <= running_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_beat_r  <= in_data;
      fwd_hit_r  <= row_wr_g.en && (row_wr_g.addr == in_data.row_index);
      fwd_word_r <= row_wr_g.data;
    end
    if (commit) begin
      out_beat_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_beat_r;

  `STSI_ASSERT(a_rows_bound, rows_loaded_r <= ROWS_LIMIT, "row count past limit")
  `STSI_ASSERT(a_total_bound, {1'b0, running_total_r} <= NZ_LIMIT, "prefix sum past limit")
  `STSI_ASSERT(a_hold_on_stall, (s1_v_r && out_v_r && out_stall) |-> in_stall,
               "input taken while update stage blocked")
  `STSI_ASSERT(a_out_follows, (s1_v_r && !in_stall) |=> out_v_r,
               "update stage drained without a result")

endmodule

// File: hw/rtl/stsi_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module stsi_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/stsi_update.sv
// Per-beat update: row declare, entry slot lookup, clear; forms result
// and row-table write. Depends on stsi_pkg.
module stsi_update (
  input  stsi_pkg::in_beat_t               beat,
  input  stsi_pkg::row_word_t              row_word,
  input  logic [stsi_pkg::CNT_W-1:0]       rows_loaded,
  input  logic [stsi_pkg::POS_W-1:0]       running_total,
  output stsi_pkg::out_beat_t              result,
  output stsi_pkg::row_wr_t                row_wr,
  output logic [stsi_pkg::CNT_W-1:0]       rows_loaded_nxt,
  output logic [stsi_pkg::POS_W-1:0]       running_total_nxt
);
  import stsi_pkg::*;

  logic [SUM_W-1:0] total;
  logic             row_loaded;
  logic             row_full;

  assign total      = {1'b0, running_total} + {1'b0, beat.row_size};
  assign row_loaded = {1'b0, beat.row_index} < rows_loaded;
  assign row_full   = row_word.fill_ptr >= row_word.end_slot;

  always_comb begin
    result            = '0;
    row_wr            = '0;
    rows_loaded_nxt   = rows_loaded;
    running_total_nxt = running_total;
    case (beat.operation)
      OP_DECLARE: begin
        result.position = running_total;
        if (rows_loaded >= ROWS_LIMIT) begin
          result.status = ST_TOO_MANY_ROWS;
        end else if (total > NZ_LIMIT) begin
          result.status = ST_OVERFLOW;
        end else begin
          result.status         = ST_OK;
          row_wr.en             = 1'b1;
          row_wr.addr           = rows_loaded[ROW_W-1:0];
          row_wr.data.fill_ptr  = running_total;
          row_wr.data.end_slot  = total[POS_W-1:0];
          running_total_nxt     = total[POS_W-1:0];
          rows_loaded_nxt       = rows_loaded + CNT_W'(1);
        end
      end
      OP_ENTRY: begin
        result.out_col       = beat.col_index;
        result.out_coef_bits = beat.coef_bits;
        if (!row_loaded) begin
          result.status = ST_NOT_LOADED;
        end else if (row_full) begin
          result.status = ST_ROW_FULL;
        end else begin
          result.status        = ST_OK;
          result.position      = row_word.fill_ptr;
          row_wr.en            = 1'b1;
          row_wr.addr          = beat.row_index;
          row_wr.data.fill_ptr = row_word.fill_ptr + POS_W'(1);
          row_wr.data.end_slot = row_word.end_slot;
        end
      end
      OP_CLEAR: begin
        rows_loaded_nxt   = '0;
        running_total_nxt = '0;
      end
      default: begin
      end
    endcase
  end

endmodule
